>>> rtl/core/sliding_mean_filter_macros.svh
// Assertion macros for the sliding mean filter checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef SLIDING_MEAN_FILTER_MACROS_SVH
`define SLIDING_MEAN_FILTER_MACROS_SVH

// Clocked property, switched off while reset is held.
`define SMF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sliding_mean_filter: property violated");

// Expression that must never be true at a clock edge.
`define SMF_NEVER(label, expr) `SMF_ASSERT(label, !(expr))

`endif

>>> rtl/core/smf_pkg.sv
// Shared constants, types and register codes of the sliding mean filter.
// No dependencies; used by the divider, the top level and the checker.
package smf_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_WIDTH = 16;

    localparam int POS_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + POS_W + 1;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(64);

    // Register index, taken from paddr[2].
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE
    } smf_state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } smf_div_req_t;

endpackage

>>> rtl/core/smf_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module smf_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/smf_divider.sv
// Radix-2 restoring divider: signed running sum by unsigned sample count.
// One quotient bit per cycle. Depends on smf_pkg.
module smf_divider
    import smf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  smf_div_req_t     req,
    output logic             busy,
    output logic [SUM_W-1:0] quotient
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  dvsr_reg;
    logic              neg_reg;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        diff    = shifted - {1'b0, dvsr_reg};
        fits    = shifted >= {1'b0, dvsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // The dividend register shifts out its bits at the top while the quotient
    // bits come in at the bottom.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg  <= req.dividend[SUM_W-1];
            quo_reg  <= req.dividend[SUM_W-1] ? (~req.dividend + SUM_W'(1)) : req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

endmodule

>>> rtl/core/sliding_mean_filter.sv
// Sliding mean filter: average of the most recent window_length samples.
// A new sample is taken only once the mean of the last one is in the output register;
// the 23-step bit-serial divider turns the running sum into the mean.
// The ring is read on the input transfer and written back as the divider starts.
// Reset (rst_n, asynchronous, active low) clears sum, position, fill count and
// the output flag, and sets window_length to 64; the ring needs no clearing.
module sliding_mean_filter
    import smf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Sample stream in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample

    // Mean stream out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] mean

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Control and state registers.
    smf_state_t              state_reg, state_next;
    logic [CFG_W-1:0]        len_reg, len_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload registers.
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [SAMPLE_WIDTH-1:0] out_data_reg;

    logic                    in_xfer;
    logic                    cfg_wr;
    logic [CNT_W-1:0]        eff_len;
    logic                    full;
    logic [CNT_W-1:0]        pos_inc;
    logic [SAMPLE_WIDTH-1:0] ring_rd;
    logic                    ring_wr;
    logic                    load_out;
    smf_div_req_t            div_req;
    logic                    div_busy;
    logic [SUM_W-1:0]        div_quot;

    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH);
    assign pready   = 1'b1;
    assign prdata   = 32'(len_reg);

    // A length of zero acts as one; anything above the ring depth saturates.
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (len_reg > WINDOW_DEPTH)
        begin
            eff_len = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            eff_len = CNT_W'(len_reg);
        end
    end

    assign full    = count_reg >= eff_len;
    assign pos_inc = CNT_W'(pos_reg) + CNT_W'(1);

    // The ring holds one sample per entry. The oldest sample is read at the
    // write position on the input transfer and the new one goes to the same
    // entry in the following cycle. The state machine takes no new item before
    // that write, so a read never overlaps a pending write of the same entry.
    smf_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_en   (in_xfer),
        .rd_addr (pos_reg),
        .rd_data (ring_rd)
    );

    smf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Next state and outputs. The update cycle adds the new sample, takes away
    // the oldest one once the window is full, advances the position and starts
    // the divider on the new sum and count. The result waits in the divider
    // until the output register is free, so a new item may be taken while an
    // earlier mean is still waiting downstream.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        s_tready       = 1'b0;
        ring_wr        = 1'b0;
        load_out       = 1'b0;
        div_req        = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ring_wr  = 1'b1;
                sum_next = sum_reg + SUM_W'($signed(sample_reg));
                if (full)
                begin
                    sum_next   = sum_next - SUM_W'($signed(ring_rd));
                    count_next = eff_len;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                pos_next         = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];
                div_req.start    = 1'b1;
                div_req.dividend = sum_next;
                div_req.divisor  = count_next;
                state_next       = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (!div_busy && (!out_valid_reg || m_tready))
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A length write restarts the window.
        if (cfg_wr)
        begin
            len_next   = pwdata[CFG_W-1:0];
            sum_next   = '0;
            pos_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            sum_reg       <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (load_out)
        begin
            out_data_reg <= div_quot[SAMPLE_WIDTH-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/core/smf_checker.sv
// Port-level checker for the sliding mean filter, bound to the top level.
// Depends on smf_pkg and sliding_mean_filter_macros.svh.
`include "sliding_mean_filter_macros.svh"

module smf_checker
    import smf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    logic in_xfer;
    logic len_wr;

    assign in_xfer = s_tvalid && s_tready;
    assign len_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH);

    // A stalled mean keeps its value until it is taken.
    `SMF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // One item is worked at a time: no transfer in the cycle after a transfer.
    `SMF_ASSERT(a_in_gap, in_xfer |=> !s_tready)
    // The mean needs the divider, so it never shows up right after its sample.
    `SMF_NEVER(a_no_early_out, $past(in_xfer) && $rose(m_tvalid))
    // The length register reads back what was written.
    `SMF_ASSERT(a_len_readback, len_wr |=> prdata == 32'($past(pwdata[CFG_W-1:0])))

endmodule

bind sliding_mean_filter smf_checker u_smf_checker (.*);
